[rtl/core/eh_pointer_encoding_decoder_macros.svh]
`ifndef EH_POINTER_ENCODING_DECODER_MACROS_SVH
`define EH_POINTER_ENCODING_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EHPD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define EHPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ehpd_pkg.sv]
`timescale 1ns / 1ps
package ehpd_pkg;

    localparam int EHPD_ADDR_BITS = 64;
    localparam int WORD_W         = 64;

    // Value formats (low nibble of the encoding byte)
    localparam logic [3:0] FMT_ABS    = 4'h0;
    localparam logic [3:0] FMT_ULEB   = 4'h1;
    localparam logic [3:0] FMT_UDATA2 = 4'h2;
    localparam logic [3:0] FMT_UDATA4 = 4'h3;
    localparam logic [3:0] FMT_UDATA8 = 4'h4;
    localparam logic [3:0] FMT_SLEB   = 4'h9;
    localparam logic [3:0] FMT_SDATA2 = 4'hA;
    localparam logic [3:0] FMT_SDATA4 = 4'hB;
    localparam logic [3:0] FMT_SDATA8 = 4'hC;

    // Base modes (high nibble of the encoding byte)
    localparam logic [3:0] MODE_ABS   = 4'h0;
    localparam logic [3:0] MODE_PC    = 4'h1;
    localparam logic [3:0] MODE_TEXT  = 4'h2;
    localparam logic [3:0] MODE_DATA  = 4'h3;
    localparam logic [3:0] MODE_FUNC  = 4'h4;
    localparam logic [3:0] MODE_OMIT  = 4'hF;

    localparam logic [7:0] ENC_OMIT   = 8'hFF;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_FORMAT = 2'd1;
    localparam logic [1:0] ERR_BASE   = 2'd2;

    localparam logic [1:0] REG_PTR64  = 2'd0;
    localparam logic [1:0] REG_TEXT   = 2'd1;
    localparam logic [1:0] REG_DATA   = 2'd2;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic              is_encoding;
        logic [WORD_W-1:0] byte_address;
        logic [WORD_W-1:0] function_start;
    } t_in;

    typedef struct packed {
        logic [WORD_W-1:0] pointer_value;
        logic [WORD_W-1:0] raw_value;
        logic              value_was_signed;
        logic              omitted;
        logic [3:0]        relative_mode;
        logic [1:0]        error_code;
    } t_out;

endpackage

[rtl/core/eh_pointer_encoding_decoder.sv]
`timescale 1ns / 1ps
// One byte is accepted per cycle, continuously, while the output side keeps up.
// A byte that completes a pointer (or an encoding byte that is omitted or in error)
// yields a result after the registered byte decode stage and then the registered base adder.
// Synchronous active-low reset empties both stages, clears the decode state to idle,
// selects eight-byte absolute pointers and sets both base registers to zero.
`include "eh_pointer_encoding_decoder_macros.svh"
module eh_pointer_encoding_decoder
    import ehpd_pkg::*;
#(
    parameter int ADDR_BITS = EHPD_ADDR_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out              o_out_data,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [WORD_W-1:0] i_cfg_data
);

    localparam logic [WORD_W-1:0] ADDR_MASK = {WORD_W{1'b1}} >> (WORD_W - ADDR_BITS);

    // configuration
    logic              r_ptr64;
    logic [WORD_W-1:0] r_text_base;
    logic [WORD_W-1:0] r_data_base;

    // decode state
    logic [7:0]        r_enc,        n_enc;
    logic [WORD_W-1:0] r_acc,        n_acc;
    logic [3:0]        r_cnt,        n_cnt;
    logic [6:0]        r_shift,      n_shift;
    logic              r_busy,       n_busy;
    logic [WORD_W-1:0] r_start_addr, n_start_addr;
    logic [WORD_W-1:0] r_fstart,     n_fstart;

    // first stage: raw value and base, waiting for the adder
    logic              r_s1_valid;
    logic [WORD_W-1:0] r_s1_raw,  n_s1_raw;
    logic [WORD_W-1:0] r_s1_base, n_s1_base;
    logic              r_s1_sgn,  n_s1_sgn;
    logic              r_s1_omit, n_s1_omit;
    logic [3:0]        r_s1_mode, n_s1_mode;
    logic [1:0]        r_s1_err,  n_s1_err;
    logic              n_res;

    logic              r_out_valid;
    t_out              r_out;

    logic              w_s2_load;
    logic              w_accept;

    logic [3:0]        w_fmt;
    logic [3:0]        w_mode;
    logic [3:0]        w_size;
    logic              w_leb;
    logic              w_sgn;
    logic              w_known;
    logic [3:0]        w_cnt_inc;
    logic [6:0]        w_shift_inc;

    assign w_s2_load  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_s2_load;
    assign w_accept   = i_in_valid && o_in_ready;

    // The format is taken from the incoming byte for an encoding byte, else from
    // the stored encoding.
    assign w_fmt  = i_in_data.is_encoding ? i_in_data.data_byte[3:0] : r_enc[3:0];
    assign w_mode = i_in_data.is_encoding ? i_in_data.data_byte[7:4] : r_enc[7:4];
    assign w_sgn  = w_fmt[3];
    assign w_cnt_inc   = r_cnt + 4'd1;
    assign w_shift_inc = r_shift + 7'd7;

    always_comb begin
        w_size  = 4'd0;
        w_leb   = 1'b0;
        w_known = 1'b1;
        case (w_fmt)
            FMT_ABS:                 w_size = r_ptr64 ? 4'd8 : 4'd4;
            FMT_ULEB, FMT_SLEB:      w_leb  = 1'b1;
            FMT_UDATA2, FMT_SDATA2:  w_size = 4'd2;
            FMT_UDATA4, FMT_SDATA4:  w_size = 4'd4;
            FMT_UDATA8, FMT_SDATA8:  w_size = 4'd8;
            default:                 w_known = 1'b0;
        endcase
    end

    always_comb begin
        n_enc        = r_enc;
        n_acc        = r_acc;
        n_cnt        = r_cnt;
        n_shift      = r_shift;
        n_busy       = r_busy;
        n_start_addr = r_start_addr;
        n_fstart     = r_fstart;
        n_res        = 1'b0;
        n_s1_raw     = '0;
        n_s1_base    = '0;
        n_s1_sgn     = 1'b0;
        n_s1_omit    = 1'b0;
        n_s1_mode    = w_mode;
        n_s1_err     = ERR_NONE;

        if (i_in_data.is_encoding) begin
            n_busy   = 1'b0;
            n_enc    = i_in_data.data_byte;
            n_acc    = '0;
            n_cnt    = 4'd0;
            n_shift  = 7'd0;
            n_fstart = i_in_data.function_start;
            if (i_in_data.data_byte == ENC_OMIT) begin
                n_res     = 1'b1;
                n_s1_omit = 1'b1;
                n_s1_mode = MODE_OMIT;
            end else if (!w_known) begin
                n_res    = 1'b1;
                n_s1_err = ERR_FORMAT;
            end else if (w_mode > MODE_FUNC ||
                         (w_mode == MODE_FUNC && i_in_data.function_start == '0)) begin
                n_res    = 1'b1;
                n_s1_err = ERR_BASE;
            end else begin
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            if (r_cnt == 4'd0) begin
                n_start_addr = i_in_data.byte_address;
            end
            if (w_leb) begin
                // Bits that land beyond bit 63 are dropped by the shift.
                if (!r_shift[6]) begin
                    n_acc   = r_acc | ({57'd0, i_in_data.data_byte[6:0]} << r_shift[5:0]);
                    n_shift = w_shift_inc;
                end
                if (r_cnt != 4'd15) begin
                    n_cnt = w_cnt_inc;
                end
                if (!i_in_data.data_byte[7]) begin
                    n_res = 1'b1;
                    if (w_sgn && !n_shift[6] && i_in_data.data_byte[6]) begin
                        n_acc = n_acc | ({WORD_W{1'b1}} << n_shift[5:0]);
                    end
                end
            end else begin
                if (!r_cnt[3]) begin
                    n_acc = r_acc | ({56'd0, i_in_data.data_byte} << {r_cnt[2:0], 3'b000});
                end
                n_cnt = w_cnt_inc;
                if (w_cnt_inc >= w_size) begin
                    n_res = 1'b1;
                    if (w_sgn && w_size == 4'd2 && n_acc[15]) begin
                        n_acc[WORD_W-1:16] = '1;
                    end
                    if (w_sgn && w_size == 4'd4 && n_acc[31]) begin
                        n_acc[WORD_W-1:32] = '1;
                    end
                end
            end
            if (n_res) begin
                n_busy   = 1'b0;
                n_s1_raw = n_acc;
                n_s1_sgn = w_sgn;
                case (w_mode)
                    MODE_PC:   n_s1_base = n_start_addr;
                    MODE_TEXT: n_s1_base = r_text_base;
                    MODE_DATA: n_s1_base = r_data_base;
                    MODE_FUNC: n_s1_base = r_fstart;
                    default:   n_s1_base = '0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr64     <= 1'b1;
            r_text_base <= '0;
            r_data_base <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PTR64: r_ptr64     <= i_cfg_data[0];
                REG_TEXT:  r_text_base <= i_cfg_data;
                REG_DATA:  r_data_base <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc        <= '0;
            r_acc        <= '0;
            r_cnt        <= '0;
            r_shift      <= '0;
            r_busy       <= 1'b0;
            r_start_addr <= '0;
            r_fstart     <= '0;
        end else if (w_accept) begin
            r_enc        <= n_enc;
            r_acc        <= n_acc;
            r_cnt        <= n_cnt;
            r_shift      <= n_shift;
            r_busy       <= n_busy;
            r_start_addr <= n_start_addr;
            r_fstart     <= n_fstart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= n_res;
        end else if (w_s2_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && n_res) begin
            r_s1_raw  <= n_s1_raw;
            r_s1_base <= n_s1_base;
            r_s1_sgn  <= n_s1_sgn;
            r_s1_omit <= n_s1_omit;
            r_s1_mode <= n_s1_mode;
            r_s1_err  <= n_s1_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_load) begin
            r_out.pointer_value    <= (r_s1_base + r_s1_raw) & ADDR_MASK;
            r_out.raw_value        <= r_s1_raw;
            r_out.value_was_signed <= r_s1_sgn;
            r_out.omitted          <= r_s1_omit;
            r_out.relative_mode    <= r_s1_mode;
            r_out.error_code       <= r_s1_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `EHPD_ASSERT_NEXT(a_s1_holds, i_clk, i_rst_n,
        r_s1_valid && !w_s2_load, r_s1_valid,
        "decoded request lost while stalled")
    `EHPD_ASSERT_IMPL(a_omit_zero, i_clk, i_rst_n,
        o_out_valid && o_out_data.omitted,
        o_out_data.pointer_value == '0 && o_out_data.relative_mode == MODE_OMIT,
        "omitted pointer with non-zero fields")
    `EHPD_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n,
        o_out_valid && o_out_data.error_code != ERR_NONE,
        o_out_data.raw_value == '0 && o_out_data.pointer_value == '0,
        "error result with non-zero value")
    `EHPD_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n,
        w_accept && n_res, !r_busy && r_s1_valid,
        "decoder still busy after a result")

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import ehpd_pkg::*;

    localparam int NO_SIZE     = 255;
    localparam int HOLD_EVERY  = 97;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_ITEMS = 290;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              o_in_ready;
    t_in               in_data = '0;
    logic              o_out_valid;
    logic              out_ready = 1'b0;
    t_out              o_out_data;
    logic              cfg_we = 1'b0;
    logic [1:0]        cfg_index = REG_PTR64;
    logic [WORD_W-1:0] cfg_data = '0;

    eh_pointer_encoding_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Register copies and decode state of the predictor.
    logic        abs_is_64 = 1'b1;
    logic [63:0] text_base = '0;
    logic [63:0] data_base = '0;
    logic [7:0]  enc_held = '0;
    logic [63:0] acc_value = '0;
    logic [3:0]  bytes_taken = '0;
    logic [6:0]  leb_pos = '0;
    logic        in_pointer = 1'b0;
    logic [63:0] value_addr = '0;
    logic [63:0] func_base = '0;

    t_in  bytes_pending[$];
    t_out pointers_expected[$];
    int   mismatches = 0;
    int   results_seen = 0;
    int   in_max_gap = 6;
    int   out_max_gap = 6;
    int   send_wait = 0;
    int   recv_wait = 0;
    logic offer;
    logic take;
    logic [63:0] next_addr = '0;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Fixed byte count of a value format; zero means LEB128.
    function automatic int value_size(input logic [3:0] fmt);
        case (fmt)
            FMT_ABS:                 return abs_is_64 ? 8 : 4;
            FMT_ULEB, FMT_SLEB:      return 0;
            FMT_UDATA2, FMT_SDATA2:  return 2;
            FMT_UDATA4, FMT_SDATA4:  return 4;
            FMT_UDATA8, FMT_SDATA8:  return 8;
            default:                 return NO_SIZE;
        endcase
    endfunction

    task automatic decode_byte(input t_in it);
        t_out        res;
        logic [3:0]  fmt;
        logic [3:0]  mode;
        int          sz;
        logic        sgn;
        logic        done;
        logic [63:0] base;
        res = '0;
        done = 1'b0;
        if (it.is_encoding) begin
            fmt = it.data_byte[3:0];
            mode = it.data_byte[7:4];
            in_pointer = 1'b0;
            enc_held = it.data_byte;
            acc_value = '0;
            bytes_taken = '0;
            leb_pos = '0;
            func_base = it.function_start;
            res.relative_mode = mode;
            if (it.data_byte == ENC_OMIT) begin
                res.omitted = 1'b1;
                res.relative_mode = MODE_OMIT;
                done = 1'b1;
            end else if (value_size(fmt) == NO_SIZE) begin
                res.error_code = ERR_FORMAT;
                done = 1'b1;
            end else if (mode > MODE_FUNC || (mode == MODE_FUNC && it.function_start == '0)) begin
                res.error_code = ERR_BASE;
                done = 1'b1;
            end else begin
                in_pointer = 1'b1;
            end
        end else if (in_pointer) begin
            fmt = enc_held[3:0];
            mode = enc_held[7:4];
            sz = value_size(fmt);
            sgn = fmt[3];
            if (bytes_taken == 0) value_addr = it.byte_address;
            if (sz == 0) begin
                // Groups beyond bit 63 are consumed but contribute nothing.
                if (leb_pos < 64) begin
                    acc_value |= 64'(it.data_byte[6:0]) << leb_pos;
                    leb_pos = leb_pos + 7'd7;
                end
                if (bytes_taken < 15) bytes_taken++;
                if (!it.data_byte[7]) begin
                    done = 1'b1;
                    if (sgn && leb_pos < 64 && it.data_byte[6])
                        acc_value |= ~64'd0 << leb_pos;
                end
            end else begin
                if (bytes_taken < 8) acc_value |= 64'(it.data_byte) << (8 * bytes_taken);
                bytes_taken++;
                if (bytes_taken >= sz) begin
                    done = 1'b1;
                    if (sgn && sz < 8 && acc_value[8 * sz - 1])
                        acc_value |= ~64'd0 << (8 * sz);
                end
            end
            if (done) begin
                case (mode)
                    MODE_PC:   base = value_addr;
                    MODE_TEXT: base = text_base;
                    MODE_DATA: base = data_base;
                    MODE_FUNC: base = func_base;
                    default:   base = '0;
                endcase
                in_pointer = 1'b0;
                res.pointer_value = base + acc_value;
                res.raw_value = acc_value;
                res.value_was_signed = sgn;
                res.relative_mode = mode;
            end
        end
        if (done) pointers_expected.push_back(res);
    endtask

    // Sender: one request offered at a time, held until taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            offer = in_valid;
            if (in_valid && o_in_ready) begin
                decode_byte(in_data);
                offer = 1'b0;
            end
            if (!offer && bytes_pending.size() != 0) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else begin
                    in_data <= bytes_pending.pop_front();
                    offer = 1'b1;
                    send_wait = $urandom_range(0, in_max_gap);
                end
            end
            in_valid <= offer;
        end
    end

    // Receiver: checks each result and draws its next stall, with a long
    // hold-off now and then so that the block backs up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (pointers_expected.size() == 0) begin
                    report_mismatch("result arrived with nothing pending");
                end else begin
                    t_out want;
                    want = pointers_expected.pop_front();
                    if (o_out_data.pointer_value !== want.pointer_value)
                        report_mismatch($sformatf("pointer_value got %h want %h",
                            o_out_data.pointer_value, want.pointer_value));
                    if (o_out_data.raw_value !== want.raw_value)
                        report_mismatch($sformatf("raw_value got %h want %h",
                            o_out_data.raw_value, want.raw_value));
                    if (o_out_data.value_was_signed !== want.value_was_signed)
                        report_mismatch($sformatf("value_was_signed got %b want %b",
                            o_out_data.value_was_signed, want.value_was_signed));
                    if (o_out_data.omitted !== want.omitted)
                        report_mismatch($sformatf("omitted got %b want %b",
                            o_out_data.omitted, want.omitted));
                    if (o_out_data.relative_mode !== want.relative_mode)
                        report_mismatch($sformatf("relative_mode got %h want %h",
                            o_out_data.relative_mode, want.relative_mode));
                    if (o_out_data.error_code !== want.error_code)
                        report_mismatch($sformatf("error_code got %0d want %0d",
                            o_out_data.error_code, want.error_code));
                end
                results_seen++;
                if (results_seen % HOLD_EVERY == 0) recv_wait = HOLD_CYCLES;
                else recv_wait = $urandom_range(0, out_max_gap);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                take = 1'b0;
            end else begin
                take = 1'b1;
            end
            out_ready <= take;
        end
    end

    task automatic send(input logic [7:0] b, input logic enc, input logic [63:0] f);
        t_in it;
        it.data_byte = b;
        it.is_encoding = enc;
        it.byte_address = next_addr;
        it.function_start = f;
        bytes_pending.push_back(it);
        next_addr++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [3:0] pick_format();
        case ($urandom_range(0, 8))
            0: return FMT_ABS;
            1: return FMT_ULEB;
            2: return FMT_UDATA2;
            3: return FMT_UDATA4;
            4: return FMT_UDATA8;
            5: return FMT_SLEB;
            6: return FMT_SDATA2;
            7: return FMT_SDATA4;
            default: return FMT_SDATA8;
        endcase
    endfunction

    // Mostly complete pointers with random content; the rest are random
    // encoding bytes, cut-short pointers and stray value bytes.
    task automatic queue_random_stream(input int n_items);
        int          made;
        int          pick;
        int          len;
        int          sz;
        logic [3:0]  fmt;
        logic [3:0]  mode;
        logic [7:0]  b;
        logic [63:0] f;
        made = 0;
        while (made < n_items) begin
            pick = $urandom_range(0, 99);
            next_addr = ($urandom_range(0, 7) == 0) ? ~64'd0 - $urandom_range(0, 6) : rand64();
            f = rand64();
            if (pick < 86) begin
                fmt = pick_format();
                mode = 4'($urandom_range(MODE_ABS, MODE_FUNC));
                if (mode == MODE_FUNC && f == '0) f = 64'd1;
                sz = value_size(fmt);
                if (sz == 0) len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 13)
                                                              : $urandom_range(1, 4);
                else len = sz;
                // A cut-short pointer is dropped when the next encoding byte arrives.
                if (pick >= 78) len = $urandom_range(0, len - 1);
                send({mode, fmt}, 1'b1, f);
                for (int i = 0; i < len; i++) begin
                    b = 8'($urandom);
                    if (sz == 0) b[7] = (i < len - 1) || (pick >= 78);
                    send(b, 1'b0, rand64());
                end
                made += len + 1;
            end else if (pick < 94) begin
                b = 8'($urandom);
                if ($urandom_range(0, 1) == 0) f = '0;
                send(b, 1'b1, f);
                len = $urandom_range(0, 3);
                for (int i = 0; i < len; i++) send(8'($urandom), 1'b0, rand64());
                made += len + 1;
            end else begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++) send(8'($urandom), 1'b0, rand64());
            end
        end
    endtask

    task automatic queue_directed();
        next_addr = 64'hFFFF_FFFF_FFFF_FFFA;
        send(8'h80, 1'b0, '0);                          // stray byte while idle
        send(ENC_OMIT, 1'b1, rand64());
        send({MODE_ABS, 4'h7}, 1'b1, '0);               // unknown format
        send({4'h5, FMT_UDATA2}, 1'b1, 64'd1);          // base mode above MODE_FUNC
        send({MODE_FUNC, FMT_UDATA2}, 1'b1, '0);        // function start of zero
        send({MODE_DATA, FMT_SDATA2}, 1'b1, '0);
        send(8'h00, 1'b0, '0);
        send(8'h80, 1'b0, '0);
        send({MODE_PC, FMT_UDATA2}, 1'b1, '0);
        send(8'hFF, 1'b0, '0);
        send({MODE_ABS, FMT_SLEB}, 1'b1, ~64'd0);       // restart mid-pointer
        send(8'h40, 1'b0, ~64'd0);
        send({MODE_FUNC, FMT_SDATA8}, 1'b1, ~64'd0);
        for (int i = 0; i < 8; i++) send(8'hFF, 1'b0, ~64'd0);
        send({MODE_TEXT, FMT_ULEB}, 1'b1, '0);
        send(8'h80, 1'b0, '0);
        send(8'h00, 1'b0, '0);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_PTR64: abs_is_64 = value[0];
            REG_TEXT:  text_base = value;
            REG_DATA:  data_base = value;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (bytes_pending.size() != 0 || in_valid || pointers_expected.size() != 0)
            @(negedge i_clk);
        // Dropped pointers and stray bytes give no result but may still be in flight.
        repeat (6) @(negedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        queue_directed();
        drain();
        for (int phase = 1; phase <= 5; phase++) begin
            case (phase)
                1: begin
                    cfg_write(REG_PTR64, 64'd0);
                    cfg_write(REG_TEXT, ~64'd0);
                    cfg_write(REG_DATA, 64'd0);
                    in_max_gap = 0;
                    out_max_gap = 0;
                end
                2: begin
                    cfg_write(REG_PTR64, 64'd1);
                    cfg_write(REG_TEXT, 64'd0);
                    cfg_write(REG_DATA, ~64'd0);
                    in_max_gap = 0;
                    out_max_gap = 6;
                end
                3: begin
                    cfg_write(REG_PTR64, 64'd0);
                    cfg_write(REG_TEXT, rand64());
                    cfg_write(REG_DATA, rand64());
                    in_max_gap = 6;
                    out_max_gap = 0;
                end
                4: begin
                    cfg_write(REG_PTR64, 64'd1);
                    cfg_write(REG_TEXT, rand64());
                    cfg_write(REG_DATA, rand64());
                    in_max_gap = 6;
                    out_max_gap = 6;
                end
                default: begin
                    cfg_write(REG_PTR64, 64'($urandom_range(0, 1)));
                    cfg_write(REG_TEXT, rand64());
                    cfg_write(REG_DATA, rand64());
                    in_max_gap = 3;
                    out_max_gap = 3;
                end
            endcase
            @(posedge i_clk);
            cfg_we <= 1'b0;
            queue_random_stream(PHASE_ITEMS);
            drain();
        end
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/ehpd_pkg.sv
rtl/core/eh_pointer_encoding_decoder.sv
sim/testbench.sv
